### rtl/lgrf_pkg.sv
`default_nettype none

package lgrf_pkg;

   // defaults for the top level parameters
   localparam int MAX_RUN_DEF      = 32;
   localparam int SINE_ENTRIES_DEF = 1024;

   // field widths
   localparam int RANGE_W  = 16;
   localparam int TILT_W   = 16;
   localparam int ANGLE_W  = 16;
   localparam int HEIGHT_W = 14;
   localparam int SENSOR_W = 13;
   localparam int MINRUN_W = 6;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_FILTER_ENABLE = 3'd0;
   localparam csr_idx_type CSR_FLOOR_HEIGHT  = 3'd1;
   localparam csr_idx_type CSR_CEIL_HEIGHT   = 3'd2;
   localparam csr_idx_type CSR_SENSOR_HEIGHT = 3'd3;
   localparam csr_idx_type CSR_MOUNT_YAW     = 3'd4;
   localparam csr_idx_type CSR_MIN_RUN       = 3'd5;
   localparam csr_idx_type CSR_START_ANGLE   = 3'd6;
   localparam csr_idx_type CSR_ANGLE_STEP    = 3'd7;

   // sine polynomial coefficients, Q14
   localparam logic [16:0] SIN_C1 = 17'd51472;
   localparam logic [16:0] SIN_C2 = 17'd21167;
   localparam logic [15:0] SIN_C3 = 16'd2463;
   localparam logic [15:0] QUARTER_TURN = 16'd16384;

endpackage

`default_nettype wire

### rtl/lgrf_if.sv
`default_nettype none

// beam item channel
interface lgrf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [lgrf_pkg::RANGE_W-1:0]   range_mm;
   logic                                  range_finite;
   logic signed [lgrf_pkg::TILT_W-1:0]    tilt_x;
   logic signed [lgrf_pkg::TILT_W-1:0]    tilt_y;
   logic                                  tilt_valid;
   logic                                  scan_end;

   modport source (output valid, range_mm, range_finite, tilt_x, tilt_y, tilt_valid,
                   scan_end, input ready);
   modport sink   (input valid, range_mm, range_finite, tilt_x, tilt_y, tilt_valid,
                   scan_end, output ready);
endinterface

// filtered beam item channel
interface lgrf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lgrf_pkg::RANGE_W-1:0]        out_range_mm;
   logic                                out_finite;
   logic                                out_scan_end;
   logic                                out_last;

   modport source (output valid, out_range_mm, out_finite, out_scan_end, out_last,
                   input ready);
   modport sink   (input valid, out_range_mm, out_finite, out_scan_end, out_last,
                   output ready);
endinterface

`default_nettype wire

### rtl/lgrf_ram.sv
`default_nettype none

module lgrf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/lidar_ground_run_filter.sv
// Ground and overhead stripping filter for the beams of a lidar scan. Beams enter on req_ch,
// filtered beams leave on rsp_ch, each with out_last on the final item a beam causes and
// out_scan_end on the final item of a scan. For a beam whose height projection is needed,
// sine and cosine come from a Q14 polynomial evaluated on one bit-serial
// shift-add multiplier (eight products), then the tilt dot product and the range product
// run one bit per cycle. Beams that skip the projection (filter off, invalid tilt,
// non-finite) go straight to classification. Each released held beam takes one read of
// the hold memory and one output load. A new beam is taken only when the previous one
// has handed all its items to the output register.
// SINE_ENTRIES must be a power of two.
`default_nettype none

module lidar_ground_run_filter #(
   parameter int MAX_RUN      = lgrf_pkg::MAX_RUN_DEF,
   parameter int SINE_ENTRIES = lgrf_pkg::SINE_ENTRIES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire lgrf_pkg::csr_idx_type                 csr_index,
   input  wire logic [lgrf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   lgrf_req_if.sink                                   req_ch,
   lgrf_rsp_if.source                                 rsp_ch
);

   localparam int CNT_W  = $clog2(MAX_RUN + 1);
   localparam int ADDR_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
   localparam int CMP_W  = 7;
   localparam int SIN_SH = 16 - $clog2(SINE_ENTRIES);
   localparam logic [15:0] ANG_MASK = 16'(32'hFFFF << SIN_SH);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MSET = 4'd1;
   localparam logic [3:0] S_MRUN = 4'd2;
   localparam logic [3:0] S_ZQ   = 4'd3;
   localparam logic [3:0] S_HP   = 4'd4;
   localparam logic [3:0] S_DEC  = 4'd5;
   localparam logic [3:0] S_RD   = 4'd6;
   localparam logic [3:0] S_WR   = 4'd7;
   localparam logic [3:0] S_SGL  = 4'd8;

   // configuration registers
   logic                               en_ff;
   logic signed [lgrf_pkg::HEIGHT_W-1:0] floor_ff, ceil_ff;
   logic [lgrf_pkg::SENSOR_W-1:0]      sensor_ff;
   logic [15:0]                        yaw_ff, start_ff, step_ff;
   logic [lgrf_pkg::MINRUN_W-1:0]      minrun_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff     <= 1'b1;
         floor_ff  <= 14'sd80;
         ceil_ff   <= 14'sd1500;
         sensor_ff <= 13'd300;
         yaw_ff    <= '0;
         minrun_ff <= 6'd8;
         start_ff  <= '0;
         step_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            lgrf_pkg::CSR_FILTER_ENABLE: en_ff     <= csr_wdata[0];
            lgrf_pkg::CSR_FLOOR_HEIGHT:  floor_ff  <= csr_wdata[13:0];
            lgrf_pkg::CSR_CEIL_HEIGHT:   ceil_ff   <= csr_wdata[13:0];
            lgrf_pkg::CSR_SENSOR_HEIGHT: sensor_ff <= csr_wdata[12:0];
            lgrf_pkg::CSR_MOUNT_YAW:     yaw_ff    <= csr_wdata;
            lgrf_pkg::CSR_MIN_RUN:       minrun_ff <= csr_wdata[5:0];
            lgrf_pkg::CSR_START_ANGLE:   start_ff  <= csr_wdata;
            lgrf_pkg::CSR_ANGLE_STEP:    step_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   logic [3:0]       state_ff, state_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [1:0]       sub_ff, sub_in;
   logic             ph_ff, ph_in;
   logic             first_ff, first_in;
   logic             lact_ff, lact_in;
   logic             commit_ff, commit_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] rel_cnt_ff, rel_cnt_in;
   logic             rel_fin_ff, rel_fin_in;
   logic             single_ff, single_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [15:0]        beam_ang_ff, beam_ang_in;
   logic [15:0]        ang_ff, ang_in;
   logic signed [15:0] ltx_ff, ltx_in, lty_ff, lty_in;
   logic [15:0]        range_ff, range_in;
   logic               fin_ff, fin_in, end_ff, end_in, calc_ff, calc_in;
   logic [1:0]         q_ff, q_in;
   logic [14:0]        t_ff, t_in, t2_ff, t2_in;
   logic [15:0]        opa_ff, opa_in;
   logic [14:0]        opb_ff, opb_in;
   logic [30:0]        macc_ff, macc_in;
   logic signed [16:0] cos_ff, cos_in, sin_ff, sin_in;
   logic [15:0]        tx_sh_ff, tx_sh_in, ty_sh_ff, ty_sh_in, r_sh_ff, r_sh_in;
   logic signed [34:0] zacc_ff, zacc_in;
   logic signed [48:0] pacc_ff, pacc_in;
   logic [15:0]        sgl_range_ff, sgl_range_in;
   logic               sgl_fin_ff, sgl_fin_in;
   logic [15:0]        o_range_ff, o_range_in;
   logic               o_fin_ff, o_fin_in, o_end_ff, o_end_in, o_last_ff, o_last_in;

   // hold memory
   logic              ram_we;
   logic [15:0]       ram_rd_data;

   lgrf_ram #(
      .WIDTH (lgrf_pkg::RANGE_W),
      .DEPTH (MAX_RUN)
   ) u_hold_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (held_ff[ADDR_W-1:0]),
      .wr_data (range_ff),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // datapath helpers
   logic [15:0]        a_ph, p_ang;
   logic [14:0]        x_off;
   logic [30:0]        macc_nx;
   logic [16:0]        prod_hi;
   logic signed [16:0] s_val;
   logic signed [34:0] term_x, term_y, term;
   logic signed [48:0] pacc_add;
   logic signed [18:0] q_hi;
   logic signed [19:0] q_ext, d_ceil, d_floor;
   logic               rem_nz, is_over, is_ground;
   logic [CMP_W-1:0]   min_run;
   logic [CNT_W-1:0]   cnt_plus;
   logic               out_free, accept, start_ang_first;
   logic [15:0]        ang_use;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && (state_ff == S_IDLE);

   // sine argument: quantize to the table grid, fold into the first quadrant
   assign a_ph  = ph_ff ? ang_ff : ang_ff + lgrf_pkg::QUARTER_TURN;
   assign p_ang = a_ph & ANG_MASK;
   assign x_off = {1'b0, p_ang[13:0]};

   // one bit-serial multiply step, multiplier msb first
   assign macc_nx = {macc_ff[29:0], 1'b0} + (opb_ff[14] ? 31'(opa_ff) : 31'd0);
   assign prod_hi = macc_nx[30:14];
   assign s_val   = q_ff[1] ? -$signed({1'b0, prod_hi[15:0]}) : $signed({1'b0, prod_hi[15:0]});

   // tilt dot product step, sign bit weighted negative
   assign term_x = tx_sh_ff[15] ? 35'(cos_ff) : 35'sd0;
   assign term_y = ty_sh_ff[15] ? 35'(sin_ff) : 35'sd0;
   assign term   = term_x + term_y;

   // range product step
   assign pacc_add = r_sh_ff[15] ? 49'(zacc_ff) : 49'sd0;

   // height compare against thresholds, sensor height moved to the threshold side
   assign q_hi    = pacc_ff[48:30];
   assign q_ext   = 20'(q_hi);
   assign rem_nz  = |pacc_ff[29:0];
   assign d_ceil  = 20'(ceil_ff) - 20'($signed({1'b0, sensor_ff}));
   assign d_floor = 20'(floor_ff) - 20'($signed({1'b0, sensor_ff}));
   assign is_over   = calc_ff && ((q_ext > d_ceil) || ((q_ext == d_ceil) && rem_nz));
   assign is_ground = calc_ff && !is_over && (q_ext < d_floor);

   // effective minimum run length
   always_comb begin
      min_run = CMP_W'(minrun_ff);
      if (minrun_ff == '0) begin
         min_run = CMP_W'(1);
      end else if (min_run > CMP_W'(MAX_RUN)) begin
         min_run = CMP_W'(MAX_RUN);
      end
   end

   assign cnt_plus        = held_ff + CNT_W'(1);
   assign start_ang_first = first_ff;
   assign ang_use         = start_ang_first ? start_ff + yaw_ff : beam_ang_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sub_in       = sub_ff;
      ph_in        = ph_ff;
      first_in     = first_ff;
      lact_in      = lact_ff;
      commit_in    = commit_ff;
      held_in      = held_ff;
      idx_in       = idx_ff;
      rel_cnt_in   = rel_cnt_ff;
      rel_fin_in   = rel_fin_ff;
      single_in    = single_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      beam_ang_in  = beam_ang_ff;
      ang_in       = ang_ff;
      ltx_in       = ltx_ff;
      lty_in       = lty_ff;
      range_in     = range_ff;
      fin_in       = fin_ff;
      end_in       = end_ff;
      calc_in      = calc_ff;
      q_in         = q_ff;
      t_in         = t_ff;
      t2_in        = t2_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      macc_in      = macc_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      tx_sh_in     = tx_sh_ff;
      ty_sh_in     = ty_sh_ff;
      r_sh_in      = r_sh_ff;
      zacc_in      = zacc_ff;
      pacc_in      = pacc_ff;
      sgl_range_in = sgl_range_ff;
      sgl_fin_in   = sgl_fin_ff;
      o_range_in   = o_range_ff;
      o_fin_in     = o_fin_ff;
      o_end_in     = o_end_ff;
      o_last_in    = o_last_ff;
      ram_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               range_in = req_ch.range_mm;
               fin_in   = req_ch.range_finite;
               end_in   = req_ch.scan_end;
               ang_in   = ang_use;
               beam_ang_in = ang_use + step_ff;
               ph_in    = 1'b0;
               if (first_ff) begin
                  ltx_in   = req_ch.tilt_x;
                  lty_in   = req_ch.tilt_y;
                  lact_in  = en_ff && req_ch.tilt_valid;
                  first_in = 1'b0;
                  calc_in  = req_ch.range_finite && en_ff && req_ch.tilt_valid;
               end else begin
                  calc_in  = req_ch.range_finite && lact_ff;
               end
               state_in = calc_in ? S_MSET : S_DEC;
            end
         end
         // load t for the current angle and start t*t
         S_MSET: begin
            q_in     = p_ang[15:14];
            t_in     = p_ang[14] ? 15'd16384 - x_off : x_off;
            opa_in   = 16'(t_in);
            opb_in   = t_in;
            macc_in  = '0;
            cnt_in   = 4'd14;
            sub_in   = 2'd0;
            state_in = S_MRUN;
         end
         // shared serial multiplier, four products per sine value
         S_MRUN: begin
            macc_in = macc_nx;
            opb_in  = {opb_ff[13:0], 1'b0};
            cnt_in  = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               macc_in = '0;
               cnt_in  = 4'd14;
               sub_in  = sub_ff + 2'd1;
               unique case (sub_ff)
                  2'd0: begin
                     t2_in  = prod_hi[14:0];
                     opa_in = lgrf_pkg::SIN_C3;
                     opb_in = prod_hi[14:0];
                  end
                  2'd1: begin
                     opa_in = 16'(lgrf_pkg::SIN_C2 - prod_hi);
                     opb_in = t2_ff;
                  end
                  2'd2: begin
                     opa_in = 16'(lgrf_pkg::SIN_C1 - prod_hi);
                     opb_in = t_ff;
                  end
                  2'd3: begin
                     if (!ph_ff) begin
                        cos_in   = s_val;
                        ph_in    = 1'b1;
                        state_in = S_MSET;
                     end else begin
                        sin_in   = s_val;
                        tx_sh_in = ltx_ff;
                        ty_sh_in = lty_ff;
                        zacc_in  = '0;
                        cnt_in   = 4'd15;
                        state_in = S_ZQ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // tilt dot product, one tilt bit per cycle
         S_ZQ: begin
            zacc_in  = (zacc_ff <<< 1) + ((cnt_ff == 4'd15) ? -term : term);
            tx_sh_in = {tx_sh_ff[14:0], 1'b0};
            ty_sh_in = {ty_sh_ff[14:0], 1'b0};
            cnt_in   = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               r_sh_in  = range_ff;
               pacc_in  = '0;
               cnt_in   = 4'd15;
               state_in = S_HP;
            end
         end
         // range times dot product, one range bit per cycle
         S_HP: begin
            pacc_in = (pacc_ff <<< 1) + pacc_add;
            r_sh_in = {r_sh_ff[14:0], 1'b0};
            cnt_in  = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = S_DEC;
            end
         end
         // classify and plan the items of this beam
         S_DEC: begin
            rel_cnt_in   = '0;
            rel_fin_in   = 1'b1;
            single_in    = 1'b0;
            sgl_range_in = '0;
            sgl_fin_in   = 1'b0;
            if (is_ground) begin
               if (commit_ff) begin
                  single_in = 1'b1;
               end else begin
                  ram_we = 1'b1;
                  if (CMP_W'(cnt_plus) >= min_run) begin
                     rel_cnt_in = cnt_plus;
                     rel_fin_in = 1'b0;
                     commit_in  = 1'b1;
                     held_in    = '0;
                  end else if (end_ff) begin
                     rel_cnt_in = cnt_plus;
                     held_in    = '0;
                  end else begin
                     held_in    = cnt_plus;
                  end
               end
            end else begin
               rel_cnt_in   = held_ff;
               held_in      = '0;
               commit_in    = 1'b0;
               single_in    = 1'b1;
               sgl_range_in = (is_over || !fin_ff) ? 16'd0 : range_ff;
               sgl_fin_in   = !is_over && fin_ff;
            end
            if (end_ff) begin
               commit_in = 1'b0;
               first_in  = 1'b1;
            end
            idx_in = '0;
            if (rel_cnt_in != '0) begin
               state_in = S_RD;
            end else if (single_in) begin
               state_in = S_SGL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         // hand one released beam to the output register
         S_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_range_in   = rel_fin_ff ? ram_rd_data : 16'd0;
               o_fin_in     = rel_fin_ff;
               o_last_in    = (idx_ff == rel_cnt_ff - CNT_W'(1)) && !single_ff;
               o_end_in     = o_last_in && end_ff;
               idx_in       = idx_ff + CNT_W'(1);
               if (idx_ff == rel_cnt_ff - CNT_W'(1)) begin
                  state_in = single_ff ? S_SGL : S_IDLE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_SGL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_range_in   = sgl_range_ff;
               o_fin_in     = sgl_fin_ff;
               o_last_in    = 1'b1;
               o_end_in     = end_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sub_ff       <= '0;
         ph_ff        <= 1'b0;
         first_ff     <= 1'b1;
         lact_ff      <= 1'b0;
         commit_ff    <= 1'b0;
         held_ff      <= '0;
         idx_ff       <= '0;
         rel_cnt_ff   <= '0;
         rel_fin_ff   <= 1'b0;
         single_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ltx_ff       <= '0;
         lty_ff       <= '0;
         beam_ang_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sub_ff       <= sub_in;
         ph_ff        <= ph_in;
         first_ff     <= first_in;
         lact_ff      <= lact_in;
         commit_ff    <= commit_in;
         held_ff      <= held_in;
         idx_ff       <= idx_in;
         rel_cnt_ff   <= rel_cnt_in;
         rel_fin_ff   <= rel_fin_in;
         single_ff    <= single_in;
         rsp_valid_ff <= rsp_valid_in;
         ltx_ff       <= ltx_in;
         lty_ff       <= lty_in;
         beam_ang_ff  <= beam_ang_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ang_ff       <= ang_in;
      range_ff     <= range_in;
      fin_ff       <= fin_in;
      end_ff       <= end_in;
      calc_ff      <= calc_in;
      q_ff         <= q_in;
      t_ff         <= t_in;
      t2_ff        <= t2_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      macc_ff      <= macc_in;
      cos_ff       <= cos_in;
      sin_ff       <= sin_in;
      tx_sh_ff     <= tx_sh_in;
      ty_sh_ff     <= ty_sh_in;
      r_sh_ff      <= r_sh_in;
      zacc_ff      <= zacc_in;
      pacc_ff      <= pacc_in;
      sgl_range_ff <= sgl_range_in;
      sgl_fin_ff   <= sgl_fin_in;
      o_range_ff   <= o_range_in;
      o_fin_ff     <= o_fin_in;
      o_end_ff     <= o_end_in;
      o_last_ff    <= o_last_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_range_mm = o_range_ff;
   assign rsp_ch.out_finite   = o_fin_ff;
   assign rsp_ch.out_scan_end = o_end_ff;
   assign rsp_ch.out_last     = o_last_ff;

   // held run never fills the hold memory between beams
   assert property (@(posedge clock) disable iff (reset) held_ff < CNT_W'(MAX_RUN))
      else $error("held run count out of range");

   // a committed run holds nothing back
   assert property (@(posedge clock) disable iff (reset) commit_ff |-> (held_ff == '0))
      else $error("committed run with held beams");

   // waiting for a new scan leaves no run state behind
   assert property (@(posedge clock) disable iff (reset)
      first_ff |-> ((held_ff == '0) && !commit_ff))
      else $error("run state left over at scan start");

endmodule

`default_nettype wire
